// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is held.
`define BTHAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BTHAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/bthal_pkg.sv
package bthal_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned OwnerW = 16;
  localparam int unsigned CountW = 9;
  localparam int unsigned SlackW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [SlackW-1:0] ResetSlack = 8'd30;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_FREE    = 3'd1;
  localparam logic [2:0] CMD_QUERY   = 3'd2;
  localparam logic [2:0] CMD_FREE_OWN = 3'd3;
  localparam logic [2:0] CMD_REALLOC = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REUSE_SLACK = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_RELEASE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MODE_FIND,
    MODE_FIT,
    MODE_OWNER
  } mode_e;

  typedef struct packed {
    logic [AddrW-1:0]  address;
    logic [SizeW-1:0]  size;
    logic [OwnerW-1:0] owner;
    logic              reserved;
  } entry_t;

  typedef struct packed {
    logic [AddrW-1:0]  granted_address;
    logic [1:0]        status;
    logic              found_flag;
    logic [SizeW-1:0]  clear_length;
    logic [AddrW-1:0]  copy_source;
    logic [SizeW-1:0]  copy_length;
    logic [SizeW-1:0]  reserved_bytes_now;
    logic [CountW-1:0] reserved_blocks_now;
    logic [CountW-1:0] table_blocks_now;
  } result_t;

endpackage

// File: sv/bthal_mem.sv
// Block record table: one write port, one read port, registered read data.
module bthal_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned IdxW  = 8
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  output bthal_pkg::entry_t     rd_data_o,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_idx_i,
  input  bthal_pkg::entry_t     wr_data_i
);

  bthal_pkg::entry_t mem_q [Depth];
  bthal_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/bthal_ctrl.sv
// Command sequencer: scans the record table one entry per cycle and
// updates records, the bump pointer and the usage counters.
module bthal_ctrl #(
  parameter int unsigned MaxBlocks = 256,
  parameter int unsigned IdxW      = 8,
  parameter int unsigned CntW      = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             cmd_i,
  input  logic [31:0]            req_size_i,
  input  logic [31:0]            req_address_i,
  input  logic                   clear_wanted_i,
  input  logic                   no_reuse_i,
  input  logic [15:0]            owner_id_i,
  input  logic                   cfg_we_i,
  input  logic [bthal_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bthal_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                   rd_en_o,
  output logic [IdxW-1:0]        rd_idx_o,
  input  bthal_pkg::entry_t      rd_data_i,
  output logic                   wr_en_o,
  output logic [IdxW-1:0]        wr_idx_o,
  output bthal_pkg::entry_t      wr_data_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output bthal_pkg::result_t     res_o
);

  localparam logic [CntW-1:0] MaxCount = CntW'(MaxBlocks);

  bthal_pkg::state_e state_q, state_d;
  bthal_pkg::mode_e  mode_q, mode_d;

  logic [CntW-1:0] idx_q, idx_d, count_q, count_d, blocks_q, blocks_d;
  logic            rvalid_q, rvalid_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic [31:0]     bytes_q, bytes_d, bump_q, bump_d;
  logic [7:0]      slack_q, slack_d;

  logic [2:0]      cmd_q, cmd_d;
  logic [31:0]     size_q, size_d, addr_q, addr_d;
  logic            clear_q, clear_d;
  logic [15:0]     owner_q, owner_d;
  logic            old_found_q, old_found_d;
  logic [IdxW-1:0] s_idx_q, s_idx_d;
  logic [31:0]     s_size_q, s_size_d;
  bthal_pkg::result_t res_q, res_d;

  logic match, hit, more;

  always_comb begin
    case (mode_q)
      bthal_pkg::MODE_FIND:
        match = rd_data_i.reserved && (rd_data_i.address == addr_q);
      bthal_pkg::MODE_FIT:
        match = !rd_data_i.reserved && (rd_data_i.address != '0) &&
                (size_q <= rd_data_i.size) &&
                ((rd_data_i.size - size_q) <= 32'(slack_q));
      bthal_pkg::MODE_OWNER:
        match = rd_data_i.reserved && (rd_data_i.owner == owner_q);
      default:
        match = 1'b0;
    endcase
  end

  assign hit  = rvalid_q && match;
  assign more = (idx_q != count_q);

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    idx_d = idx_q;
    rvalid_d = 1'b0;
    ridx_d = ridx_q;
    count_d = count_q;
    blocks_d = blocks_q;
    bytes_d = bytes_q;
    bump_d = bump_q;
    slack_d = slack_q;
    cmd_d = cmd_q;
    size_d = size_q;
    addr_d = addr_q;
    clear_d = clear_q;
    owner_d = owner_q;
    old_found_d = old_found_q;
    s_idx_d = s_idx_q;
    s_size_d = s_size_q;
    res_d = res_q;
    in_ready_o = 1'b0;
    rd_en_o = 1'b0;
    rd_idx_o = idx_q[IdxW-1:0];
    wr_en_o = 1'b0;
    wr_idx_o = ridx_q;
    wr_data_o = rd_data_i;
    res_valid_o = 1'b0;

    if (cfg_we_i) begin
      if (cfg_index_i == bthal_pkg::CFG_HEAP_BASE) begin
        if (count_q == '0) begin
          bump_d = cfg_data_i;
        end
      end else if (cfg_index_i == bthal_pkg::CFG_REUSE_SLACK) begin
        slack_d = cfg_data_i[7:0];
      end
    end

    case (state_q)
      bthal_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = cmd_i;
          size_d = req_size_i;
          addr_d = req_address_i;
          clear_d = clear_wanted_i;
          owner_d = owner_id_i;
          old_found_d = 1'b0;
          res_d = '0;
          idx_d = '0;
          state_d = bthal_pkg::ST_SCAN;
          case (cmd_i)
            bthal_pkg::CMD_ALLOC: begin
              mode_d = bthal_pkg::MODE_FIT;
              if (no_reuse_i) begin
                state_d = bthal_pkg::ST_APPEND;
              end
            end
            bthal_pkg::CMD_FREE, bthal_pkg::CMD_QUERY, bthal_pkg::CMD_REALLOC: begin
              mode_d = bthal_pkg::MODE_FIND;
            end
            bthal_pkg::CMD_FREE_OWN: begin
              mode_d = bthal_pkg::MODE_OWNER;
            end
            default: begin
              state_d = bthal_pkg::ST_DONE;
            end
          endcase
        end
      end

      bthal_pkg::ST_SCAN: begin
        if (mode_q == bthal_pkg::MODE_OWNER) begin
          if (hit) begin
            wr_en_o = 1'b1;
            wr_data_o.reserved = 1'b0;
            wr_data_o.owner = '0;
            bytes_d = bytes_q - rd_data_i.size;
            blocks_d = blocks_q - 1'b1;
          end
          if (more) begin
            rd_en_o = 1'b1;
            rvalid_d = 1'b1;
            ridx_d = idx_q[IdxW-1:0];
            idx_d = idx_q + 1'b1;
          end else begin
            state_d = bthal_pkg::ST_DONE;
          end
        end else if (hit) begin
          if (mode_q == bthal_pkg::MODE_FIND) begin
            case (cmd_q)
              bthal_pkg::CMD_FREE: begin
                wr_en_o = 1'b1;
                wr_data_o.reserved = 1'b0;
                wr_data_o.owner = '0;
                bytes_d = bytes_q - rd_data_i.size;
                blocks_d = blocks_q - 1'b1;
                res_d.found_flag = 1'b1;
                state_d = bthal_pkg::ST_DONE;
              end
              bthal_pkg::CMD_QUERY: begin
                res_d.found_flag = 1'b1;
                state_d = bthal_pkg::ST_DONE;
              end
              default: begin
                // Reallocate: keep the block when it is large enough.
                old_found_d = 1'b1;
                s_idx_d = ridx_q;
                s_size_d = rd_data_i.size;
                if (size_q <= rd_data_i.size) begin
                  res_d.granted_address = addr_q;
                  state_d = bthal_pkg::ST_DONE;
                end else begin
                  mode_d = bthal_pkg::MODE_FIT;
                  idx_d = '0;
                end
              end
            endcase
          end else begin
            // First fitting freed block is taken over as it is.
            wr_en_o = 1'b1;
            wr_data_o.reserved = 1'b1;
            wr_data_o.owner = owner_q;
            bytes_d = bytes_q + rd_data_i.size;
            blocks_d = blocks_q + 1'b1;
            res_d.granted_address = rd_data_i.address;
            res_d.clear_length = clear_q ? rd_data_i.size : '0;
            state_d = old_found_q ? bthal_pkg::ST_RELEASE : bthal_pkg::ST_DONE;
          end
        end else if (more) begin
          rd_en_o = 1'b1;
          rvalid_d = 1'b1;
          ridx_d = idx_q[IdxW-1:0];
          idx_d = idx_q + 1'b1;
        end else if (mode_q == bthal_pkg::MODE_FIND) begin
          if (cmd_q == bthal_pkg::CMD_REALLOC) begin
            mode_d = bthal_pkg::MODE_FIT;
            idx_d = '0;
          end else begin
            res_d.status = bthal_pkg::STATUS_NOT_FOUND;
            state_d = bthal_pkg::ST_DONE;
          end
        end else begin
          state_d = bthal_pkg::ST_APPEND;
        end
      end

      bthal_pkg::ST_APPEND: begin
        if (count_q == MaxCount) begin
          res_d.status = bthal_pkg::STATUS_FULL;
          state_d = bthal_pkg::ST_DONE;
        end else begin
          wr_en_o = 1'b1;
          wr_idx_o = count_q[IdxW-1:0];
          wr_data_o.address = bump_q;
          wr_data_o.size = size_q;
          wr_data_o.owner = owner_q;
          wr_data_o.reserved = 1'b1;
          count_d = count_q + 1'b1;
          bytes_d = bytes_q + size_q;
          blocks_d = blocks_q + 1'b1;
          bump_d = bump_q + size_q + 32'd1;
          res_d.granted_address = bump_q;
          res_d.clear_length = clear_q ? size_q : '0;
          state_d = old_found_q ? bthal_pkg::ST_RELEASE : bthal_pkg::ST_DONE;
        end
      end

      bthal_pkg::ST_RELEASE: begin
        wr_en_o = 1'b1;
        wr_idx_o = s_idx_q;
        wr_data_o.address = addr_q;
        wr_data_o.size = s_size_q;
        wr_data_o.owner = '0;
        wr_data_o.reserved = 1'b0;
        bytes_d = bytes_q - s_size_q;
        blocks_d = blocks_q - 1'b1;
        res_d.copy_source = addr_q;
        res_d.copy_length = s_size_q;
        state_d = bthal_pkg::ST_DONE;
      end

      bthal_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = bthal_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bthal_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o = res_q;
    res_o.reserved_bytes_now = bytes_q;
    res_o.reserved_blocks_now = bthal_pkg::CountW'(blocks_q);
    res_o.table_blocks_now = bthal_pkg::CountW'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bthal_pkg::ST_IDLE;
      mode_q <= bthal_pkg::MODE_FIND;
      idx_q <= '0;
      rvalid_q <= 1'b0;
      count_q <= '0;
      blocks_q <= '0;
      bytes_q <= '0;
      bump_q <= '0;
      slack_q <= bthal_pkg::ResetSlack;
      old_found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      idx_q <= idx_d;
      rvalid_q <= rvalid_d;
      count_q <= count_d;
      blocks_q <= blocks_d;
      bytes_q <= bytes_d;
      bump_q <= bump_d;
      slack_q <= slack_d;
      old_found_q <= old_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    cmd_q <= cmd_d;
    size_q <= size_d;
    addr_q <= addr_d;
    clear_q <= clear_d;
    owner_q <= owner_d;
    s_idx_q <= s_idx_d;
    s_size_q <= s_size_d;
    res_q <= res_d;
  end

endmodule

// File: sv/block_table_heap_allocator_unit.sv
// First-fit block allocator with a bump pointer. Each command beat returns
// exactly one result beat. Allocate scans the block table for a freed block
// that fits within the reuse slack and otherwise appends a block at the bump
// pointer (no_reuse skips the scan); free, query, free-by-owner and
// reallocate act on the same table. Zero filling and copying are not
// performed here but reported as requests. The table lives in a single-port-
// read, single-port-write memory and is scanned one entry per cycle; a
// reallocate that moves its block scans it again for a fitting freed block.
// Entries are never cleared after reset: only slots below the block count
// are read. heap_base loads the bump pointer only while the table is empty.
// Configuration writes are only allowed while no item is in flight.
module block_table_heap_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] req_address_i,
  input  logic        clear_wanted_i,
  input  logic        no_reuse_i,
  input  logic [15:0] owner_id_i,
  input  logic        cfg_we_i,
  input  logic [bthal_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bthal_pkg::CfgDataW-1:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o,
  output logic        found_flag_o,
  output logic [31:0] clear_length_o,
  output logic [31:0] copy_source_o,
  output logic [31:0] copy_length_o,
  output logic [31:0] reserved_bytes_now_o,
  output logic [8:0]  reserved_blocks_now_o,
  output logic [8:0]  table_blocks_now_o
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  logic              rd_en, wr_en;
  logic [IdxW-1:0]   rd_idx, wr_idx;
  bthal_pkg::entry_t rd_data, wr_data;
  logic              res_valid, res_ready;
  bthal_pkg::result_t res, out_q;
  logic              out_valid_q;

  bthal_mem #(
    .Depth (MAX_BLOCKS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data)
  );

  bthal_ctrl #(
    .MaxBlocks (MAX_BLOCKS),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .req_size_i     (req_size_i),
    .req_address_i  (req_address_i),
    .clear_wanted_i (clear_wanted_i),
    .no_reuse_i     (no_reuse_i),
    .owner_id_i     (owner_id_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rd_en_o        (rd_en),
    .rd_idx_o       (rd_idx),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_idx_o       (wr_idx),
    .wr_data_o      (wr_data),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // Output register: the sequencer moves on to the next beat while a
  // finished result still waits here for the consumer.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign granted_address_o     = out_q.granted_address;
  assign status_o              = out_q.status;
  assign found_flag_o          = out_q.found_flag;
  assign clear_length_o        = out_q.clear_length;
  assign copy_source_o         = out_q.copy_source;
  assign copy_length_o         = out_q.copy_length;
  assign reserved_bytes_now_o  = out_q.reserved_bytes_now;
  assign reserved_blocks_now_o = out_q.reserved_blocks_now;
  assign table_blocks_now_o    = out_q.table_blocks_now;

endmodule

// File: sv/bthal_checker.sv
`include "assert_macros.svh"

module bthal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] granted_address_o,
  input logic [1:0]  status_o,
  input logic        found_flag_o,
  input logic [31:0] copy_length_o
);

  `BTHAL_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |=> !out_valid_o, "result beat during reset")

  `BTHAL_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o), "result beat dropped while stalled")

  `BTHAL_ASSERT(a_status_code, out_valid_o |-> status_o <= bthal_pkg::STATUS_FULL, "unknown status code")

  `BTHAL_ASSERT(a_found_ok, out_valid_o && found_flag_o |-> status_o == bthal_pkg::STATUS_OK && granted_address_o == 32'd0, "found flag with grant or error")

  `BTHAL_ASSERT(a_full_nogrant, out_valid_o && status_o == bthal_pkg::STATUS_FULL |-> granted_address_o == 32'd0 && copy_length_o == 32'd0, "full table yet grant or copy")

endmodule

bind block_table_heap_allocator_unit bthal_checker u_bthal_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .granted_address_o (granted_address_o),
  .status_o          (status_o),
  .found_flag_o      (found_flag_o),
  .copy_length_o     (copy_length_o)
);

// File: tb/tb_top.sv
module tb_top;

  // One command beat as the driver presents it.
  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] size;
    logic [31:0] address;
    logic        clear;
    logic        no_reuse;
    logic [15:0] owner;
  } alloc_cmd_t;

  // Scoreboard: keeps its own copy of the block table and works out the
  // result of every accepted command, then matches result beats in order.
  class alloc_scoreboard;
    logic [31:0] tab_addr [256];
    logic [31:0] tab_size [256];
    logic [15:0] tab_owner [256];
    bit          tab_busy [256];
    int unsigned n_blocks = 0;
    logic [31:0] bytes_held = 0;
    logic [8:0]  blocks_held = 0;
    logic [31:0] bump = 0;
    logic [7:0]  slack_reg = bthal_pkg::ResetSlack;
    bthal_pkg::result_t waiting [$];
    logic [31:0] handed_out [$];
    int          errors = 0;
    int          checked = 0;
    int          full_hits = 0;
    int          moves = 0;

    function void write_reg(logic [bthal_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
      if (idx == bthal_pkg::CFG_HEAP_BASE) begin
        if (n_blocks == 0) bump = val;
      end else if (idx == bthal_pkg::CFG_REUSE_SLACK) begin
        slack_reg = val[7:0];
      end
    endfunction

    function int lookup(logic [31:0] a);
      for (int i = 0; i < n_blocks; i++)
        if (tab_busy[i] && tab_addr[i] == a) return i;
      return -1;
    endfunction

    function void drop(int i);
      tab_busy[i] = 0;
      tab_owner[i] = '0;
      bytes_held -= tab_size[i];
      blocks_held -= 1;
    endfunction

    // First fit among freed blocks, then an append at the bump pointer.
    function bit take_block(logic [31:0] sz, bit reuse, logic [15:0] own,
                            output logic [31:0] a, output logic [31:0] g);
      if (reuse) begin
        for (int i = 0; i < n_blocks; i++) begin
          if (tab_busy[i] || tab_addr[i] == 0) continue;
          if (sz > tab_size[i] || tab_size[i] - sz > {24'd0, slack_reg}) continue;
          tab_owner[i] = own;
          tab_busy[i] = 1;
          bytes_held += tab_size[i];
          blocks_held += 1;
          a = tab_addr[i];
          g = tab_size[i];
          return 1;
        end
      end
      if (n_blocks >= 256) return 0;
      tab_addr[n_blocks] = bump;
      tab_size[n_blocks] = sz;
      tab_owner[n_blocks] = own;
      tab_busy[n_blocks] = 1;
      n_blocks++;
      bytes_held += sz;
      blocks_held += 1;
      a = bump;
      g = sz;
      bump += sz + 1;
      return 1;
    endfunction

    function void note_command(alloc_cmd_t c);
      bthal_pkg::result_t r;
      logic [31:0] a, g;
      int s;
      r = '0;
      case (c.cmd)
        bthal_pkg::CMD_ALLOC: begin
          if (take_block(c.size, !c.no_reuse, c.owner, a, g)) begin
            r.granted_address = a;
            r.clear_length = c.clear ? g : '0;
            handed_out.push_back(a);
          end else begin
            r.status = bthal_pkg::STATUS_FULL;
            full_hits++;
          end
        end
        bthal_pkg::CMD_FREE: begin
          s = lookup(c.address);
          if (s >= 0) begin
            drop(s);
            r.found_flag = 1;
          end else r.status = bthal_pkg::STATUS_NOT_FOUND;
        end
        bthal_pkg::CMD_QUERY: begin
          if (lookup(c.address) >= 0) r.found_flag = 1;
          else r.status = bthal_pkg::STATUS_NOT_FOUND;
        end
        bthal_pkg::CMD_FREE_OWN: begin
          for (int i = 0; i < n_blocks; i++)
            if (tab_busy[i] && tab_owner[i] == c.owner) drop(i);
        end
        bthal_pkg::CMD_REALLOC: begin
          s = lookup(c.address);
          if (s >= 0 && c.size <= tab_size[s]) begin
            r.granted_address = c.address;
          end else if (take_block(c.size, 1'b1, c.owner, a, g)) begin
            r.granted_address = a;
            r.clear_length = c.clear ? g : '0;
            handed_out.push_back(a);
            if (s >= 0) begin
              r.copy_source = c.address;
              r.copy_length = tab_size[s];
              drop(s);
              moves++;
            end
          end else begin
            r.status = bthal_pkg::STATUS_FULL;
            full_hits++;
          end
        end
        default: ;
      endcase
      r.reserved_bytes_now = bytes_held;
      r.reserved_blocks_now = blocks_held;
      r.table_blocks_now = n_blocks[8:0];
      waiting.push_back(r);
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] g);
      $display("%0t: mismatch on %s: expected %h, got %h", $time, f, e, g);
      errors++;
    endfunction

    function void check_result(bthal_pkg::result_t got);
      bthal_pkg::result_t e;
      checked++;
      if (waiting.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
        return;
      end
      e = waiting.pop_front();
      if (got.granted_address !== e.granted_address)
        report("granted_address", e.granted_address, got.granted_address);
      if (got.status !== e.status) report("status", e.status, got.status);
      if (got.found_flag !== e.found_flag) report("found_flag", e.found_flag, got.found_flag);
      if (got.clear_length !== e.clear_length)
        report("clear_length", e.clear_length, got.clear_length);
      if (got.copy_source !== e.copy_source)
        report("copy_source", e.copy_source, got.copy_source);
      if (got.copy_length !== e.copy_length)
        report("copy_length", e.copy_length, got.copy_length);
      if (got.reserved_bytes_now !== e.reserved_bytes_now)
        report("reserved_bytes_now", e.reserved_bytes_now, got.reserved_bytes_now);
      if (got.reserved_blocks_now !== e.reserved_blocks_now)
        report("reserved_blocks_now", e.reserved_blocks_now, got.reserved_blocks_now);
      if (got.table_blocks_now !== e.table_blocks_now)
        report("table_blocks_now", e.table_blocks_now, got.table_blocks_now);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i = '0;
  logic [31:0] req_size_i = '0;
  logic [31:0] req_address_i = '0;
  logic        clear_wanted_i = 1'b0;
  logic        no_reuse_i = 1'b0;
  logic [15:0] owner_id_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [bthal_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [bthal_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] granted_address_o;
  logic [1:0]  status_o;
  logic        found_flag_o;
  logic [31:0] clear_length_o;
  logic [31:0] copy_source_o;
  logic [31:0] copy_length_o;
  logic [31:0] reserved_bytes_now_o;
  logic [8:0]  reserved_blocks_now_o;
  logic [8:0]  table_blocks_now_o;

  alloc_scoreboard sb = new;

  // Both sides idle in a per-phase style; when eager is set, neither idles.
  bit eager = 0;
  int sink_hold = 0;
  int sent = 0;

  block_table_heap_allocator_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung handshake; far above the slowest correct run.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (eager) return 0;
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // The result side: ready changes only at the falling edge and is held for a
  // random stretch so stalls land on every phase of the block's work.
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (eager) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
      sink_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{granted_address_o, status_o, found_flag_o, clear_length_o,
                        copy_source_o, copy_length_o, reserved_bytes_now_o,
                        reserved_blocks_now_o, table_blocks_now_o});
  end

  // Called at a falling edge, returns at a falling edge. Valid is lowered only
  // when a gap follows, so back-to-back beats keep it high without a glitch.
  task automatic send_cmd(alloc_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c.cmd;
    req_size_i <= c.size;
    req_address_i <= c.address;
    clear_wanted_i <= c.clear;
    no_reuse_i <= c.no_reuse;
    owner_id_i <= c.owner;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(c);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send(logic [2:0] cmd, logic [31:0] size, logic [31:0] addr,
                      logic clr, logic nr, logic [15:0] own);
    alloc_cmd_t c;
    c = '{cmd, size, addr, clr, nr, own};
    send_cmd(c);
  endtask

  // Registers are only written with the block idle: every result is back.
  task automatic write_reg(logic [bthal_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    in_valid_i <= 1'b0;
    while (sb.waiting.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 64);
    if (p < 92) return $urandom_range(0, 300);
    return $urandom;
  endfunction

  // Mostly addresses that were really handed out, so frees and queries hit.
  function automatic logic [31:0] rand_addr();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70 && sb.handed_out.size() > 0)
      return sb.handed_out[$urandom_range(0, sb.handed_out.size() - 1)];
    if (p < 85) return $urandom_range(0, 600);
    return $urandom;
  endfunction

  function automatic logic [15:0] rand_owner();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) return $urandom_range(1, 6);
    if (p < 93) return '0;
    return $urandom;
  endfunction

  // A run of random commands; alloc_pct sets how fast the table fills.
  task automatic random_phase(int count, int alloc_pct, int no_reuse_pct);
    alloc_cmd_t c;
    int p;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      c.size = rand_size();
      c.address = rand_addr();
      c.clear = $urandom_range(0, 1);
      c.no_reuse = ($urandom_range(0, 99) < no_reuse_pct);
      c.owner = rand_owner();
      if (p < alloc_pct) c.cmd = bthal_pkg::CMD_ALLOC;
      else if (p < alloc_pct + (100 - alloc_pct) * 35 / 100) c.cmd = bthal_pkg::CMD_FREE;
      else if (p < alloc_pct + (100 - alloc_pct) * 55 / 100) c.cmd = bthal_pkg::CMD_QUERY;
      else if (p < alloc_pct + (100 - alloc_pct) * 85 / 100) c.cmd = bthal_pkg::CMD_REALLOC;
      else if (p < 98) c.cmd = bthal_pkg::CMD_FREE_OWN;
      else c.cmd = 3'(bthal_pkg::CMD_REALLOC + $urandom_range(1, 3));
      if (c.cmd == bthal_pkg::CMD_FREE_OWN && $urandom_range(0, 3) != 0)
        c.owner = $urandom_range(1, 6);
      send_cmd(c);
      if (n % 40 == 39) eager = ~eager;
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Both heap_base writes land while the table is empty; the last one wins,
    // so the very first block sits at address zero.
    write_reg(bthal_pkg::CFG_HEAP_BASE, 32'hFFFF_FFF0);
    write_reg(bthal_pkg::CFG_HEAP_BASE, 32'h0);

    // Directed opening with the default slack of 30.
    send(bthal_pkg::CMD_QUERY, 0, 0, 0, 0, 1);          // miss on an empty table
    send(bthal_pkg::CMD_FREE, 0, 5, 0, 0, 1);           // free miss
    send(bthal_pkg::CMD_ALLOC, 0, 0, 1, 0, 1);          // zero-size block at 0
    send(bthal_pkg::CMD_ALLOC, 100, 0, 1, 0, 2);
    send(bthal_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 0, 1, 1, 16'hFFFF); // bump pointer wraps
    send(bthal_pkg::CMD_ALLOC, 10, 0, 0, 1, 3);         // duplicate address
    send(bthal_pkg::CMD_QUERY, 0, 102, 0, 0, 0);
    send(bthal_pkg::CMD_FREE, 0, 102, 0, 0, 0);         // lowest slot goes first
    send(bthal_pkg::CMD_QUERY, 0, 102, 0, 0, 0);
    send(bthal_pkg::CMD_FREE, 0, 0, 0, 0, 0);           // block at address zero
    send(bthal_pkg::CMD_ALLOC, 0, 0, 0, 0, 4);          // zero address not reused
    send(bthal_pkg::CMD_FREE, 0, 1, 0, 0, 0);
    send(bthal_pkg::CMD_ALLOC, 80, 0, 1, 0, 5);         // reuse keeps its size
    send(bthal_pkg::CMD_REALLOC, 50, 1, 1, 0, 5);       // shrink keeps the block
    send(bthal_pkg::CMD_REALLOC, 200, 1, 1, 1, 5);      // move with clear and copy
    send(bthal_pkg::CMD_REALLOC, 8, 32'hDEAD_BEEF, 1, 1, 6); // unknown address allocates
    send(bthal_pkg::CMD_FREE_OWN, 0, 0, 0, 0, 5);
    send(bthal_pkg::CMD_FREE_OWN, 0, 0, 0, 0, 0);
    send(3'(bthal_pkg::CMD_REALLOC + 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);
    send(3'(bthal_pkg::CMD_REALLOC + 2), 0, 0, 0, 0, 0);
    send(3'(bthal_pkg::CMD_REALLOC + 3), 1, 1, 1, 1, 1);
    send(bthal_pkg::CMD_ALLOC, 30, 0, 1, 0, 7);
    send(bthal_pkg::CMD_FREE, 0, 32'hFFFF_FFFF, 0, 0, 0);

    // Random phases across the slack extremes. heap_base is rewritten too;
    // with blocks in the table it must leave the bump pointer alone.
    write_reg(bthal_pkg::CFG_REUSE_SLACK, 32'd0);
    write_reg(bthal_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
    random_phase(180, 45, 30);
    write_reg(bthal_pkg::CFG_REUSE_SLACK, 32'd255);
    random_phase(190, 70, 60);                       // drives the table full
    write_reg(bthal_pkg::CFG_REUSE_SLACK, $urandom_range(0, 255));
    write_reg(bthal_pkg::CFG_HEAP_BASE, $urandom);
    random_phase(180, 40, 20);
    write_reg(bthal_pkg::CFG_REUSE_SLACK, 32'd30);
    random_phase(180, 45, 30);

    in_valid_i <= 1'b0;
    waited = 0;
    while (sb.waiting.size() != 0 && waited < 100_000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (600) @(negedge clk_i);

    $display("Ran %0d commands, checked %0d results; table ended with %0d blocks.",
             sent, sb.checked, sb.n_blocks);
    $display("Saw %0d table-full answers and %0d reallocate moves.",
             sb.full_hits, sb.moves);
    if (sb.errors == 0 && sb.waiting.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.waiting.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.waiting.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
